// ===== design/lwct_pkg.sv =====
// shared types and codes of the cache tag controller
package lwct_pkg;

    // kind of memory request carried by a result item
    typedef enum logic [1:0] {
        REQ_NONE      = 2'd0,
        REQ_FILL      = 2'd1,
        REQ_WRITEBACK = 2'd2
    } t_req_kind;

    // access operation codes
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // width of the address fields on the ports
    localparam int unsigned PORT_ADDR_W = 48;

endpackage

// ===== design/lru_writeback_cache_tags.sv =====
// top level: tag, valid, dirty and lru controller of a set-associative write-back cache
//
// Each accepted item is a read or write access. The block looks up the set in a
// row memory that holds, per set, every way's tag, valid and dirty bit and the lru
// order of the ways, then writes the updated row back. A hit gives one result; a
// miss gives a read fill, preceded by a writeback when a dirty way is evicted.
// Items are handled one at a time: between acceptance and ready the block reads the
// set's row from the single row memory, looks it up, writes it back and emits its
// results, and a stalled output holds it in the emitting states. The final result
// sits in an output register, so the next item is taken while it waits. After reset
// a clearing pass initializes the rows, during which no item is accepted. SETS and
// BLOCK_BYTES are meant to be powers of two, where the set and tag extraction reduce
// to bit selects.
module lru_writeback_cache_tags
    import lwct_pkg::*;
#(
    parameter int unsigned SETS         = 64,
    parameter int unsigned WAYS         = 8,
    parameter int unsigned BLOCK_BYTES  = 64,
    parameter int unsigned ADDRESS_BITS = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_operation,
    input  logic [PORT_ADDR_W-1:0] i_address,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic                   o_hit,
    output logic [1:0]             o_request_kind,
    output logic [PORT_ADDR_W-1:0] o_memory_address,
    output logic                   o_last
);

    localparam int unsigned AW    = ADDRESS_BITS;
    localparam int unsigned BLK_W = AW - ($clog2(BLOCK_BYTES + 1) - 1);
    localparam int unsigned TAG_W = BLK_W - ($clog2(SETS + 1) - 1);
    localparam int unsigned SW    = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int unsigned WW    = (WAYS > 1) ? $clog2(WAYS) : 1;

    // one memory row: everything the block keeps about a set
    typedef struct packed {
        logic [WAYS-1:0][WW-1:0]    order;
        logic [WAYS-1:0]            dirty;
        logic [WAYS-1:0]            valid;
        logic [WAYS-1:0][TAG_W-1:0] tags;
    } t_row;

    localparam int unsigned ROW_W = $bits(t_row);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_UPDATE,
        S_WB,
        S_LAST
    } t_state;

    t_state            r_state;
    logic [SW-1:0]     r_clr;
    logic              r_write;
    logic [BLK_W-1:0]  r_block;
    logic [SW-1:0]     r_set;
    logic [TAG_W-1:0]  r_tag;
    t_row              r_row;
    logic              r_hit;
    logic [WW-1:0]     r_way;
    logic              r_wb;
    logic              r_out_valid;
    logic              r_out_hit;
    t_req_kind         r_out_kind;
    logic [PORT_ADDR_W-1:0] r_out_addr;
    logic              r_out_last;

    logic [63:0]       w_addr64;
    logic [AW-1:0]     w_addr;
    logic [BLK_W-1:0]  w_block;
    logic [SW-1:0]     w_set;
    logic [TAG_W-1:0]  w_tag;
    t_row              w_row;
    logic              w_hit;
    logic [WW-1:0]     w_way;
    logic              w_wb;
    t_row              w_new_row;
    t_row              w_init_row;
    logic [BLK_W-1:0]  w_vblock;
    logic [AW-1:0]     w_vaddr;
    logic [AW-1:0]     w_line;
    logic [63:0]       w_vaddr64;
    logic [63:0]       w_line64;
    logic              w_out_free;
    logic              w_mem_we;
    logic [SW-1:0]     w_mem_waddr;
    logic [ROW_W-1:0]  w_mem_wdata;
    logic [ROW_W-1:0]  w_mem_rdata;

    // set and tag of the incoming access
    assign w_addr64 = 64'(i_address);
    assign w_addr   = w_addr64[AW-1:0];
    assign w_block  = BLK_W'(w_addr / BLOCK_BYTES);
    assign w_set    = SW'(w_block % SETS);
    assign w_tag    = TAG_W'(w_block / SETS);

    // row memory
    lwct_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_set),
        .o_rdata (w_mem_rdata)
    );

    assign w_row = t_row'(w_mem_rdata);

    // lookup: tag compare on all ways, free way search, lru victim
    always_comb begin
        logic          found;
        logic          free_found;
        logic [WW-1:0] free_way;
        found      = 1'b0;
        free_found = 1'b0;
        free_way   = '0;
        w_way      = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!found && w_row.valid[w] && (w_row.tags[w] == r_tag)) begin
                found = 1'b1;
                w_way = WW'(w);
            end
            if (!free_found && !w_row.valid[w]) begin
                free_found = 1'b1;
                free_way   = WW'(w);
            end
        end
        w_hit = found;
        w_wb  = 1'b0;
        if (!found) begin
            if (free_found) begin
                w_way = free_way;
            end else begin
                w_way = w_row.order[0];
                if (int'(w_row.order[0]) >= int'(WAYS)) begin
                    w_way = '0;
                end
                w_wb = w_row.dirty[w_way];
            end
        end
    end

    // updated row: line state and the way moved to most recent
    always_comb begin
        logic [WAYS-1:0] at_or_after;
        logic            seen;
        w_new_row = r_row;
        if (r_hit) begin
            w_new_row.dirty[r_way] = r_row.dirty[r_way] | (r_write == OP_WRITE);
        end else begin
            w_new_row.tags[r_way]  = r_tag;
            w_new_row.valid[r_way] = 1'b1;
            w_new_row.dirty[r_way] = (r_write == OP_WRITE);
        end
        seen = 1'b0;
        for (int p = 0; p < WAYS; p++) begin
            seen           = seen | (r_row.order[p] == r_way);
            at_or_after[p] = seen;
        end
        for (int p = 0; p < WAYS - 1; p++) begin
            if (at_or_after[p]) begin
                w_new_row.order[p] = r_row.order[p + 1];
            end
        end
        if (at_or_after[WAYS-1]) begin
            w_new_row.order[WAYS-1] = r_way;
        end
    end

    // row written by the clearing pass
    always_comb begin
        w_init_row       = '0;
        for (int w = 0; w < WAYS; w++) begin
            w_init_row.order[w] = WW'(w);
        end
    end

    // memory addresses of the results
    assign w_vblock  = BLK_W'(r_row.tags[r_way]) * BLK_W'(SETS) + BLK_W'(r_set);
    assign w_vaddr   = AW'(w_vblock) * AW'(BLOCK_BYTES);
    assign w_line    = AW'(r_block) * AW'(BLOCK_BYTES);
    assign w_vaddr64 = 64'(w_vaddr);
    assign w_line64  = 64'(w_line);

    // memory write: clearing pass or row write-back
    assign w_mem_we    = (r_state == S_CLEAR) || (r_state == S_UPDATE);
    assign w_mem_waddr = (r_state == S_CLEAR) ? r_clr : r_set;
    assign w_mem_wdata = (r_state == S_CLEAR) ? ROW_W'(w_init_row) : ROW_W'(w_new_row);

    assign w_out_free = !r_out_valid || i_out_ready;

    // control sequence and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a taken item leaves the register empty unless a new one is loaded
            if (r_out_valid && i_out_ready &&
                (r_state != S_WB) && (r_state != S_LAST)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SW'(1);
                    if (r_clr == SW'(SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_write <= i_operation;
                        r_block <= w_block;
                        r_set   <= w_set;
                        r_tag   <= w_tag;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_row   <= w_row;
                    r_hit   <= w_hit;
                    r_way   <= w_way;
                    r_wb    <= w_wb;
                    r_state <= S_UPDATE;
                end
                S_UPDATE: begin
                    r_state <= r_wb ? S_WB : S_LAST;
                end
                S_WB: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= 1'b0;
                        r_out_kind  <= REQ_WRITEBACK;
                        r_out_addr  <= w_vaddr64[PORT_ADDR_W-1:0];
                        r_out_last  <= 1'b0;
                        r_state     <= S_LAST;
                    end
                end
                S_LAST: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit;
                        r_out_kind  <= r_hit ? REQ_NONE : REQ_FILL;
                        r_out_addr  <= r_hit ? '0 : w_line64[PORT_ADDR_W-1:0];
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_hit            = r_out_hit;
    assign o_request_kind   = r_out_kind;
    assign o_memory_address = r_out_addr;
    assign o_last           = r_out_last;

endmodule

// ===== design/lwct_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module lwct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/testbench.sv =====
// testbench of the lru write-back cache tag controller: queued stimulus, self-predicting checks
`timescale 1ns / 1ps

module testbench;
    import lwct_pkg::*;

    localparam int unsigned NUM_SETS    = 64;
    localparam int unsigned NUM_WAYS    = 8;
    localparam int unsigned LINE_BYTES  = 64;
    localparam int unsigned ADDR_W      = 48;
    localparam int unsigned OFFSET_W    = 6;
    localparam int unsigned SET_W       = 6;
    localparam int unsigned TAG_W       = ADDR_W - OFFSET_W - SET_W;
    localparam int unsigned RANDOM_ITEMS = 1450;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
    } t_access;

    typedef struct packed {
        logic              hit;
        t_req_kind         kind;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } t_cache_result;

    // block ports; the inputs are known from time zero
    logic                   i_clk            = 1'b0;
    logic                   i_rst_n          = 1'b0;
    logic                   i_in_valid       = 1'b0;
    logic                   o_in_ready;
    logic                   i_operation      = OP_READ;
    logic [PORT_ADDR_W-1:0] i_address        = '0;
    logic                   o_out_valid;
    logic                   i_out_ready      = 1'b0;
    logic                   o_hit;
    logic [1:0]             o_request_kind;
    logic [PORT_ADDR_W-1:0] o_memory_address;
    logic                   o_last;

    // predicted cache state
    logic [TAG_W-1:0] line_tag   [NUM_SETS][NUM_WAYS];
    bit               line_valid [NUM_SETS][NUM_WAYS];
    bit               line_dirty [NUM_SETS][NUM_WAYS];
    logic [2:0]       lru_order  [NUM_SETS][NUM_WAYS];

    t_access       pending_accesses[$];
    t_cache_result expected_results[$];

    int accepted_count = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int holdoff_left   = 0;
    bit holdoff_done   = 1'b0;

    lru_writeback_cache_tags #(
        .SETS         (NUM_SETS),
        .WAYS         (NUM_WAYS),
        .BLOCK_BYTES  (LINE_BYTES),
        .ADDRESS_BITS (ADDR_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_address        (i_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_hit            (o_hit),
        .o_request_kind   (o_request_kind),
        .o_memory_address (o_memory_address),
        .o_last           (o_last)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // append one item to the stimulus queue
    function automatic void queue_access(input t_access item);
        pending_accesses.insert(pending_accesses.size(), item);
    endfunction

    // append one predicted result item
    function automatic void queue_expected(input t_cache_result item);
        expected_results.insert(expected_results.size(), item);
    endfunction

    // move a way to the most recent end of its set's order
    task automatic promote_way(input int set_idx, input int way);
        int p;
        p = 0;
        while (p < NUM_WAYS && lru_order[set_idx][p] != way)
            p++;
        for (; p + 1 < NUM_WAYS; p++)
            lru_order[set_idx][p] = lru_order[set_idx][p + 1];
        lru_order[set_idx][NUM_WAYS - 1] = 3'(way);
    endtask

    // look up one access in the predicted tags and queue the results it causes
    task automatic predict_lookup(input logic op, input logic [ADDR_W-1:0] addr);
        int            set_idx;
        int            hit_way;
        int            victim;
        logic [TAG_W-1:0] tag;
        t_cache_result res;
        set_idx = int'(addr[OFFSET_W +: SET_W]);
        tag     = addr[ADDR_W-1 -: TAG_W];
        hit_way = -1;
        victim  = -1;
        for (int w = 0; w < NUM_WAYS; w++)
            if (hit_way < 0 && line_valid[set_idx][w] && line_tag[set_idx][w] == tag)
                hit_way = w;
        if (hit_way >= 0) begin
            if (op == OP_WRITE)
                line_dirty[set_idx][hit_way] = 1'b1;
            promote_way(set_idx, hit_way);
            res = '{hit: 1'b1, kind: REQ_NONE, addr: '0, last: 1'b1};
            queue_expected(res);
        end else begin
            // lowest free way first, otherwise the least recent one
            for (int w = 0; w < NUM_WAYS; w++)
                if (victim < 0 && !line_valid[set_idx][w])
                    victim = w;
            if (victim < 0) begin
                victim = int'(lru_order[set_idx][0]);
                if (line_dirty[set_idx][victim]) begin
                    res = '{hit: 1'b0, kind: REQ_WRITEBACK,
                            addr: {line_tag[set_idx][victim], SET_W'(set_idx),
                                   OFFSET_W'(0)},
                            last: 1'b0};
                    queue_expected(res);
                end
            end
            line_tag[set_idx][victim]   = tag;
            line_valid[set_idx][victim] = 1'b1;
            line_dirty[set_idx][victim] = (op == OP_WRITE);
            promote_way(set_idx, victim);
            res = '{hit: 1'b0, kind: REQ_FILL,
                    addr: {addr[ADDR_W-1:OFFSET_W], OFFSET_W'(0)}, last: 1'b1};
            queue_expected(res);
        end
    endtask

    // sender: offer queued items, hold each until taken
    always @(posedge i_clk) begin : sender
        t_access item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_lookup(i_operation, i_address);
                accepted_count <= accepted_count + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_accesses.size() > 0 &&
                    ((accepted_count >= 600 && accepted_count < 900) ||
                     $urandom_range(0, 99) >= 7)) begin
                    item = pending_accesses.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= item.op;
                    i_address   <= item.addr;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, one long hold-off, one stretch always ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            i_out_ready  <= 1'b0;
        end else if (!holdoff_done && results_seen >= 300) begin
            holdoff_done <= 1'b1;
            holdoff_left <= 400;
            i_out_ready  <= 1'b0;
        end else if (results_seen >= 900 && results_seen < 1300) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 7);
        end
    end

    // monitor: compare each taken result with the oldest prediction
    always @(posedge i_clk) begin : monitor
        t_cache_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item: hit %0b kind %0d addr %h last %0b",
                                          o_hit, o_request_kind, o_memory_address, o_last));
            end else begin
                want = expected_results.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch($sformatf("hit %0b, want %0b", o_hit, want.hit));
                if (o_request_kind !== want.kind)
                    report_mismatch($sformatf("request kind %0d, want %s",
                                              o_request_kind, want.kind.name()));
                if (o_memory_address !== want.addr)
                    report_mismatch($sformatf("memory address %h, want %h",
                                              o_memory_address, want.addr));
                if (o_last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, want.last));
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [TAG_W-1:0]  set5_tags [10];
        logic [TAG_W-1:0]  tag_pool  [12];
        logic [SET_W-1:0]  hot_sets  [3];
        logic [ADDR_W-1:0] addr;
        logic              op;

        for (int s = 0; s < NUM_SETS; s++)
            for (int w = 0; w < NUM_WAYS; w++) begin
                line_valid[s][w] = 1'b0;
                line_dirty[s][w] = 1'b0;
                line_tag[s][w]   = '0;
                lru_order[s][w]  = 3'(w);
            end

        // directed: address extremes, hits of both kinds
        queue_access('{op: OP_READ,  addr: '0});
        queue_access('{op: OP_WRITE, addr: '1});
        queue_access('{op: OP_WRITE, addr: {{(ADDR_W-OFFSET_W){1'b1}}, OFFSET_W'(0)}});
        queue_access('{op: OP_READ,  addr: 48'h3F});
        // fill set 5 through its free ways, odd ways written
        for (int i = 0; i < 10; i++)
            set5_tags[i] = 36'hA5A5A5A50 + TAG_W'(i);
        for (int i = 0; i < NUM_WAYS; i++)
            queue_access('{op: (i % 2) ? OP_WRITE : OP_READ,
                           addr: {set5_tags[i], SET_W'(5), OFFSET_W'(i)}});
        // refresh way 0, then evict a dirty victim and a clean victim
        queue_access('{op: OP_READ,  addr: {set5_tags[0], SET_W'(5), 6'h21}});
        queue_access('{op: OP_READ,  addr: {set5_tags[8], SET_W'(5), 6'h00}});
        queue_access('{op: OP_WRITE, addr: {set5_tags[9], SET_W'(5), 6'h3F}});
        queue_access('{op: OP_WRITE, addr: {set5_tags[8], SET_W'(5), 6'h10}});
        queue_access('{op: OP_READ,  addr: {set5_tags[9], SET_W'(5), 6'h01}});

        // random: mostly a few hot sets and a small tag pool, rest anywhere
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                foreach (hot_sets[i])
                    hot_sets[i] = SET_W'($urandom());
                foreach (tag_pool[i])
                    tag_pool[i] = TAG_W'({$urandom(), $urandom()});
            end
            if ($urandom_range(0, 99) < 15)
                addr = ADDR_W'({$urandom(), $urandom()});
            else
                addr = {tag_pool[$urandom_range(0, 11)], hot_sets[$urandom_range(0, 2)],
                        OFFSET_W'($urandom())};
            op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
            queue_access('{op: op, addr: addr});
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain everything, then let the pipeline settle
        do @(negedge i_clk);
        while (pending_accesses.size() > 0 || i_in_valid || expected_results.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_results.size() > 0)
            report_mismatch($sformatf("%0d expected items never arrived",
                                      expected_results.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hang guard
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
